>>> hw/rtl/fdd_pkg.sv
// Package for the fragment deframer: codes, the result record and the
// decimal accumulator shared by the parser, the result queue and the top level.
// Depends on nothing.
package fdd_pkg;

    localparam int NUMBER_BITS = 16;
    localparam int FRAG_W      = 16;

    localparam logic [NUMBER_BITS-1:0] NUM_MAX   = '1;
    localparam logic [7:0]             FIELD_SEP = 8'h3A;
    localparam logic [7:0]             DIGIT_0   = 8'h30;
    localparam logic [7:0]             DIGIT_9   = 8'h39;

    typedef enum logic [2:0] {
        POS_IDLE    = 3'd0,
        POS_TOTAL   = 3'd1,
        POS_NUMBER  = 3'd2,
        POS_SIZE    = 3'd3,
        POS_NAME    = 3'd4,
        POS_PAYLOAD = 3'd5,
        POS_SKIP    = 3'd6
    } t_pos;

    typedef enum logic [1:0] {
        KIND_NAME    = 2'd0,
        KIND_PAYLOAD = 2'd1,
        KIND_VERDICT = 2'd2
    } t_kind;

    typedef enum logic [1:0] {
        VERD_ACCEPT = 2'd0,
        VERD_LAST   = 2'd1,
        VERD_DUP    = 2'd2
    } t_verdict;

    typedef struct packed {
        logic [1:0]        kind;
        logic [7:0]        data;
        logic [1:0]        code;
        logic [FRAG_W-1:0] frag;
        logic              last;
    } t_result;

    // Results of one byte handed to the queue, at most two per byte.
    typedef struct packed {
        logic [1:0] count;
        t_result    res0;
        t_result    res1;
    } t_push;

    // Multiply by ten and add a digit, saturating at the field maximum.
    function automatic logic [NUMBER_BITS-1:0] acc_dec(
        input logic [NUMBER_BITS-1:0] acc,
        input logic [3:0]             digit
    );
        logic [NUMBER_BITS+3:0] wide;
        logic [NUMBER_BITS+3:0] v;
        wide = (NUMBER_BITS+4)'(acc);
        v = (wide << 3) + (wide << 1) + (NUMBER_BITS+4)'(digit);
        if (v > (NUMBER_BITS+4)'(NUM_MAX)) begin
            return NUM_MAX;
        end
        return v[NUMBER_BITS-1:0];
    endfunction

    // Low bits of a number field as shown in a result.
    function automatic logic [FRAG_W-1:0] to_frag(input logic [NUMBER_BITS-1:0] x);
        logic [31:0] w;
        w = 32'(x);
        return w[FRAG_W-1:0];
    endfunction

endpackage

>>> hw/rtl/fdd_if.sv
// Valid/ready channel interfaces of the fragment deframer.
// fdd_in_if carries received bytes, fdd_out_if carries result records.
// Depends on nothing.
interface fdd_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       first_of_datagram;

    modport source (output valid, output data_byte, output first_of_datagram, input ready);
    modport sink   (input valid, input data_byte, input first_of_datagram, output ready);
endinterface

interface fdd_out_if;
    logic        valid;
    logic        ready;
    logic [1:0]  out_kind;
    logic [7:0]  out_byte;
    logic [1:0]  verdict_code;
    logic [15:0] fragment_number;
    logic        last_of_run;

    modport source (output valid, output out_kind, output out_byte, output verdict_code,
                    output fragment_number, output last_of_run, input ready);
    modport sink   (input valid, input out_kind, input out_byte, input verdict_code,
                    input fragment_number, input last_of_run, output ready);
endinterface

>>> hw/rtl/fdd_queue.sv
// Four-entry result queue of the fragment deframer; takes up to two results
// per cycle and gives one per transfer. Depends on fdd_pkg.
module fdd_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  fdd_pkg::t_push i_push,
    output logic           o_room,
    output logic           o_valid,
    input  logic           i_ready,
    output fdd_pkg::t_result o_res
);
    import fdd_pkg::*;

    t_result    r_mem [4];
    logic [1:0] r_wr_ptr, n_wr_ptr;
    logic [1:0] r_rd_ptr, n_rd_ptr;
    logic [2:0] r_count, n_count;
    logic       pop;

    assign o_valid = (r_count != 3'd0);
    assign o_res   = r_mem[r_rd_ptr];
    assign pop     = o_valid && i_ready;
    // Two free slots whatever happens at the output this cycle.
    assign o_room  = (r_count < 3'd3);

    always_comb begin
        n_wr_ptr = r_wr_ptr + 2'(i_push.count);
        n_rd_ptr = r_rd_ptr + 2'(pop);
        n_count  = r_count + 3'(i_push.count) - 3'(pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push.count != 2'd0) begin
            r_mem[r_wr_ptr] <= i_push.res0;
        end
        if (i_push.count == 2'd2) begin
            r_mem[r_wr_ptr + 2'd1] <= i_push.res1;
        end
    end

endmodule

>>> hw/rtl/fdd_parser.sv
// Datagram parser of the fragment deframer: input register, field state and
// the single-pass step logic that produces up to two results per byte.
// Depends on fdd_pkg and fdd_if.
module fdd_parser (
    input  logic           i_clk,
    input  logic           i_rst_n,
    fdd_in_if.sink         i_in,
    input  logic           i_room,
    output fdd_pkg::t_push o_push
);
    import fdd_pkg::*;

    localparam int NB = NUMBER_BITS;

    // Input register.
    logic       r_in_valid;
    logic [7:0] r_in_byte;
    logic       r_in_first;

    // Parse state.
    t_pos         r_pos, n_pos;
    logic [NB-1:0] r_total, n_total;
    logic [NB-1:0] r_frag, n_frag;
    logic [NB-1:0] r_size, n_size;
    logic [NB-1:0] r_seen, n_seen;
    logic [NB-1:0] r_high, n_high;
    logic r_ended, n_ended;
    logic r_dup, n_dup;
    logic r_started, n_started;
    logic r_done, n_done;

    logic          step, active;
    t_pos          pos_e;
    logic [NB-1:0] total_e, frag_e, size_e, seen_e;
    logic          ended_e, dup_e;
    logic          is_sep, is_digit;
    logic [3:0]    digit;
    logic [NB:0]   seen_inc;
    logic          emit_data, emit_verdict;
    t_kind         data_kind;
    t_verdict      code;
    t_result       data_res, verd_res;

    assign step   = r_in_valid && i_room;
    assign active = step && !r_done;
    assign i_in.ready = !r_in_valid || step;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in.ready) begin
            r_in_valid <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.ready && i_in.valid) begin
            r_in_byte  <= i_in.data_byte;
            r_in_first <= i_in.first_of_datagram;
        end
    end

    // A first-byte flag restarts parsing with cleared fields.
    always_comb begin
        pos_e   = r_in_first ? POS_TOTAL : r_pos;
        total_e = r_in_first ? '0 : r_total;
        frag_e  = r_in_first ? '0 : r_frag;
        size_e  = r_in_first ? '0 : r_size;
        seen_e  = r_in_first ? '0 : r_seen;
        ended_e = r_in_first ? 1'b0 : r_ended;
        dup_e   = r_in_first ? 1'b0 : r_dup;
    end

    assign is_sep   = (r_in_byte == FIELD_SEP);
    assign is_digit = !ended_e && (r_in_byte >= DIGIT_0) && (r_in_byte <= DIGIT_9);
    assign digit    = 4'(r_in_byte - DIGIT_0);
    assign seen_inc = (NB+1)'(seen_e) + (NB+1)'(1);

    assign emit_data = ((pos_e == POS_NAME) && !is_sep && !dup_e && !r_started)
                    || ((pos_e == POS_PAYLOAD) && !dup_e);
    assign emit_verdict = ((pos_e == POS_NAME) && is_sep && (size_e == '0))
                       || ((pos_e == POS_PAYLOAD) && (seen_inc >= (NB+1)'(size_e)));
    assign data_kind = (pos_e == POS_NAME) ? KIND_NAME : KIND_PAYLOAD;

    always_comb begin
        if (dup_e) begin
            code = VERD_DUP;
        end else if (frag_e == total_e) begin
            code = VERD_LAST;
        end else begin
            code = VERD_ACCEPT;
        end
    end

    // Next state.
    always_comb begin
        n_pos     = r_pos;
        n_total   = r_total;
        n_frag    = r_frag;
        n_size    = r_size;
        n_seen    = r_seen;
        n_high    = r_high;
        n_ended   = r_ended;
        n_dup     = r_dup;
        n_started = r_started;
        n_done    = r_done;
        if (active) begin
            n_pos   = pos_e;
            n_total = total_e;
            n_frag  = frag_e;
            n_size  = size_e;
            n_seen  = seen_e;
            n_ended = ended_e;
            n_dup   = dup_e;
            case (pos_e)
                POS_TOTAL, POS_NUMBER, POS_SIZE: begin
                    if (is_sep) begin
                        if (pos_e == POS_NUMBER) begin
                            n_dup = (frag_e <= r_high);
                        end
                        n_ended = 1'b0;
                        n_pos   = t_pos'(pos_e + 3'd1);
                    end else if (is_digit) begin
                        if (pos_e == POS_TOTAL) begin
                            n_total = acc_dec(total_e, digit);
                        end else if (pos_e == POS_NUMBER) begin
                            n_frag = acc_dec(frag_e, digit);
                        end else begin
                            n_size = acc_dec(size_e, digit);
                        end
                    end else begin
                        n_ended = 1'b1;
                    end
                end
                POS_NAME: begin
                    if (is_sep) begin
                        n_pos = POS_PAYLOAD;
                    end
                end
                POS_PAYLOAD: begin
                    n_seen = seen_inc[NB-1:0];
                end
                default: begin
                end
            endcase
            if (emit_verdict) begin
                n_pos = POS_SKIP;
                if (!dup_e) begin
                    n_high    = frag_e;
                    n_started = 1'b1;
                    n_done    = (code == VERD_LAST);
                end
            end
        end
    end

    // Results of this byte.
    always_comb begin
        data_res.kind = data_kind;
        data_res.data = r_in_byte;
        data_res.code = VERD_ACCEPT;
        data_res.frag = to_frag(frag_e);
        data_res.last = !emit_verdict;
        verd_res.kind = KIND_VERDICT;
        verd_res.data = '0;
        verd_res.code = code;
        verd_res.frag = to_frag(frag_e);
        verd_res.last = 1'b1;
        o_push.count = '0;
        o_push.res0  = emit_data ? data_res : verd_res;
        o_push.res1  = verd_res;
        if (active) begin
            o_push.count = 2'(emit_data) + 2'(emit_verdict);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos     <= POS_IDLE;
            r_total   <= '0;
            r_frag    <= '0;
            r_size    <= '0;
            r_seen    <= '0;
            r_high    <= '0;
            r_ended   <= 1'b0;
            r_dup     <= 1'b0;
            r_started <= 1'b0;
            r_done    <= 1'b0;
        end else begin
            r_pos     <= n_pos;
            r_total   <= n_total;
            r_frag    <= n_frag;
            r_size    <= n_size;
            r_seen    <= n_seen;
            r_high    <= n_high;
            r_ended   <= n_ended;
            r_dup     <= n_dup;
            r_started <= n_started;
            r_done    <= n_done;
        end
    end

endmodule

>>> hw/rtl/fragment_deframer_dup_filter.sv
// Fragment deframer with duplicate filter. Received datagram bytes come in one
// per transfer on i_in, the first byte of each datagram flagged. A datagram is
// "total:number:size:name:" and payload; the numbers are decimal, saturate at
// the field maximum and end at the first non-digit. Fragments whose number is
// not above the highest one accepted so far are duplicates and produce only a
// verdict. The name bytes come out for the first accepted fragment alone, the
// payload bytes for every accepted one, and a verdict follows the last payload
// byte (or the colon after the name when the size is zero). After the last
// fragment is accepted all further input is ignored; a datagram cut short by a
// new first-byte flag gives no verdict. Each byte passes through the input
// register and the step logic into the four-entry result queue, and the
// block takes one byte per cycle; a byte that yields two results (payload and
// verdict) puts both into the queue, and input stalls only while the queue
// holds three or more results.
module fragment_deframer_dup_filter (
    input  logic       i_clk,
    input  logic       i_rst_n,
    fdd_in_if.sink     i_in,
    fdd_out_if.source  o_out
);
    import fdd_pkg::*;

    t_push   push;
    logic    room;
    logic    out_valid;
    t_result out_res;

    // Parser: input register and the per-byte step.
    fdd_parser u_parser (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (i_in),
        .i_room  (room),
        .o_push  (push)
    );

    // Result queue: parts the parser from a stalled output.
    fdd_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .o_room  (room),
        .o_valid (out_valid),
        .i_ready (o_out.ready),
        .o_res   (out_res)
    );

    assign o_out.valid           = out_valid;
    assign o_out.out_kind        = out_res.kind;
    assign o_out.out_byte        = out_res.data;
    assign o_out.verdict_code    = out_res.code;
    assign o_out.fragment_number = out_res.frag;
    assign o_out.last_of_run     = out_res.last;

endmodule
